FILE: sv/lrukv_pkg.sv
// ----------------------------------------------------------------------------
// lrukv_pkg
// Shared widths, reset values and cell control type for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lrukv_pkg;

	localparam int KEY_W       = 16;
	localparam int VAL_W       = 17;
	localparam int CAP_W       = 5;
	localparam int ENTRIES_DEF = 16;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_TUSER_W = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	// broadcast to every cell for one transaction
	typedef struct packed {
		logic go;
		logic hit;
		logic put;
		logic evict;
	} ctrl_t;

endpackage

FILE: sv/lrukv_cell.sv
// ----------------------------------------------------------------------------
// lrukv_cell
// One recency slot: holds a key/value pair, matches the lookup key and takes
// its upstream neighbor's contents when the recency order shifts.
// ----------------------------------------------------------------------------
module lrukv_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lrukv_pkg::ctrl_t              ctrl,
	input  logic [lrukv_pkg::KEY_W-1:0]   lookup_key,
	input  logic [lrukv_pkg::KEY_W-1:0]   up_key,
	input  logic [lrukv_pkg::VAL_W-1:0]   up_value,
	input  logic                          up_valid,
	input  logic                          seen_in,
	output logic [lrukv_pkg::KEY_W-1:0]   key_q,
	output logic [lrukv_pkg::VAL_W-1:0]   value_q,
	output logic                          valid_q,
	output logic                          match,
	output logic                          seen_out
);

	logic take;

	assign match    = valid_q && (key_q == lookup_key);
	assign seen_out = seen_in | match;

	// hit: shift up to hit slot; miss put: up to fill slot, or all valid on evict
	always_comb begin
		if (ctrl.hit) begin
			take = ctrl.go && !seen_in;
		end else if (ctrl.put) begin
			take = ctrl.go && (ctrl.evict ? valid_q : up_valid);
		end else begin
			take = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_q   <= up_key;
			value_q <= up_value;
		end
	end

endmodule

FILE: sv/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A new transaction is accepted every cycle while the result register is free
// or being drained. The store is a row of ENTRIES cells kept in recency order,
// cell 0 most recent; all cells compare the key in the same cycle, and on a hit
// or put the row shifts by one toward the back up to the hit slot or the fill
// point. Capacity is written over the cfg channel; the user must write it only
// while idle, as the block itself does not enforce this.
module lru_key_value_cache_core #(
	parameter int ENTRIES = lrukv_pkg::ENTRIES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lrukv_pkg::CAP_W-1:0]         cfg_data,        // capacity
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [lrukv_pkg::IN_TDATA_W-1:0]    s_axis_tdata,    // key[15:0], value[32:16]
	input  logic                                s_axis_tuser,    // cmd
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [lrukv_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,    // data[16:0], evicted_key[32:17]
	output logic [lrukv_pkg::OUT_TUSER_W-1:0]   m_axis_tuser     // found[0], evicted[1]
);

	localparam int KW    = lrukv_pkg::KEY_W;
	localparam int VW    = lrukv_pkg::VAL_W;
	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = ((OCC_W > lrukv_pkg::CAP_W) ? OCC_W : lrukv_pkg::CAP_W) + 1;

	logic [lrukv_pkg::CAP_W-1:0] capacity_q;
	logic [OCC_W-1:0]            occ_q;
	logic                        out_valid_q;
	logic                        found_q;
	logic                        evicted_q;
	logic [VW-1:0]               data_q;
	logic [KW-1:0]               ev_key_q;

	logic                        accept;
	logic                        cmd;
	logic [KW-1:0]               key;
	logic [VW-1:0]               value;
	logic                        hit;
	logic                        evict;
	logic [VW-1:0]               hit_value;
	logic [KW-1:0]               last_key;
	logic [VW-1:0]               new_value;
	logic [CMP_W-1:0]            eff_cap;
	logic [CMP_W-1:0]            occ_ext;
	lrukv_pkg::ctrl_t            ctrl;

	logic [KW-1:0]               key_a   [ENTRIES];
	logic [VW-1:0]               value_a [ENTRIES];
	logic [ENTRIES-1:0]          valid_a;
	logic [ENTRIES-1:0]          match_a;
	logic [ENTRIES:0]            seen_a;
	logic [ENTRIES:0]            valid_ext;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign cmd   = s_axis_tuser;
	assign key   = s_axis_tdata[KW-1:0];
	assign value = s_axis_tdata[KW+VW-1:KW];

	assign seen_a[0] = 1'b0;
	assign hit       = seen_a[ENTRIES];
	assign valid_ext = {1'b0, valid_a};

	always_comb begin
		hit_value = '0;
		last_key  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_a[i]) begin
				hit_value = hit_value | value_a[i];
			end
			if (valid_ext[i] && !valid_ext[i+1]) begin
				last_key = last_key | key_a[i];
			end
		end
	end

	always_comb begin
		eff_cap = CMP_W'(capacity_q);
		if (capacity_q == '0) begin
			eff_cap = CMP_W'(1);
		end
		if (eff_cap > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end
	end

	assign occ_ext   = CMP_W'(occ_q);
	assign evict     = !hit && (cmd == lrukv_pkg::CMD_PUT) && (occ_q != '0)
	                   && ((occ_ext + CMP_W'(1)) > eff_cap);
	assign new_value = (cmd == lrukv_pkg::CMD_PUT) ? value : hit_value;

	assign ctrl.go    = accept;
	assign ctrl.hit   = hit;
	assign ctrl.put   = (cmd == lrukv_pkg::CMD_PUT);
	assign ctrl.evict = evict;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		if (g == 0) begin : g_head
			lrukv_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.lookup_key (key),
				.up_key     (key),
				.up_value   (new_value),
				.up_valid   (1'b1),
				.seen_in    (seen_a[g]),
				.key_q      (key_a[g]),
				.value_q    (value_a[g]),
				.valid_q    (valid_a[g]),
				.match      (match_a[g]),
				.seen_out   (seen_a[g+1])
			);
		end else begin : g_body
			lrukv_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.lookup_key (key),
				.up_key     (key_a[g-1]),
				.up_value   (value_a[g-1]),
				.up_valid   (valid_a[g-1]),
				.seen_in    (seen_a[g]),
				.key_q      (key_a[g]),
				.value_q    (value_a[g]),
				.valid_q    (valid_a[g]),
				.match      (match_a[g]),
				.seen_out   (seen_a[g+1])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= lrukv_pkg::CAP_RESET;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
			if (accept && !hit && (cmd == lrukv_pkg::CMD_PUT) && !evict) begin
				occ_q <= occ_q + OCC_W'(1);
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			found_q   <= hit;
			evicted_q <= evict;
			data_q    <= (hit && (cmd == lrukv_pkg::CMD_GET)) ? hit_value : '0;
			ev_key_q  <= evict ? last_key : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(lrukv_pkg::OUT_TDATA_W - VW - KW){1'b0}}, ev_key_q, data_q};
	assign m_axis_tuser  = {evicted_q, found_q};

endmodule

FILE: sv/lrukv_checker.sv
// ----------------------------------------------------------------------------
// lrukv_checker
// Port-level checks for the LRU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lrukv_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	input  logic                                s_axis_tready,
	input  logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic [lrukv_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input  logic [lrukv_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

	// a hit never evicts
	a_evict_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
		else $error("eviction reported together with a hit");

	a_evkey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[1] |-> (m_axis_tdata[32:17] == '0))
		else $error("evicted key nonzero without eviction");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted transaction produced no result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind lru_key_value_cache_core lrukv_checker u_lrukv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
